@@ rtl/core/pidc_pkg.sv @@
package pidc_pkg;

  localparam int DIGIT_W   = 16;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_INT_FLOOR   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INT_CEILING = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TARGET      = 3'd6;

  typedef enum logic [1:0] {
    OP_P   = 2'd0,
    OP_EDT = 2'd1,
    OP_INC = 2'd2,
    OP_DM  = 2'd3
  } mul_op_t;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_ERR   = 11'b000_0000_0010,
    ST_DIFF  = 11'b000_0000_0100,
    ST_MLOAD = 11'b000_0000_1000,
    ST_MRUN  = 11'b000_0001_0000,
    ST_MFIN  = 11'b000_0010_0000,
    ST_INTEG = 11'b000_0100_0000,
    ST_DLOAD = 11'b000_1000_0000,
    ST_DRUN  = 11'b001_0000_0000,
    ST_DFIN  = 11'b010_0000_0000,
    ST_OUT   = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    logic    load;
    logic    err;
    logic    diff;
    logic    mload;
    logic    mstep;
    logic    mfin;
    logic    integ;
    logic    dload;
    logic    dstep;
    logic    dfin;
    logic    drive;
    mul_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_last;
    logic div_last;
    logic period_zero;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/core/pidc_if.sv @@
interface pidc_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

interface pidc_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] drive;
  logic signed [DATA_WIDTH-1:0] p_term;
  logic signed [DATA_WIDTH-1:0] i_term;
  logic signed [DATA_WIDTH-1:0] d_term;

  modport source (output valid, output drive, output p_term, output i_term, output d_term,
                  input ready);
  modport sink   (input valid, input drive, input p_term, input i_term, input d_term,
                  output ready);
endinterface

@@ rtl/core/pid_controller_integral_clamp.sv @@
// Each beat runs error, difference, four passes of the shared 16-bit-digit
// multiplier, integration, the one-bit-per-cycle restoring divider (skipped
// when sample_period is zero) and the output step. A new beat is accepted
// only after the last result is loaded into the free output register.
// Reset: synchronous active-low rst_n clears settings, integrator, last error
// and the output valid; the block is ready in the first cycle after reset.
module pid_controller_integral_clamp #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pidc_in_if.sink                        in_ch,
  pidc_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [pidc_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]          cfg_wdata
);
  import pidc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pidc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pidc_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_measurement (in_ch.measurement),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_drive      (out_ch.drive),
    .out_p_term     (out_ch.p_term),
    .out_i_term     (out_ch.i_term),
    .out_d_term     (out_ch.d_term)
  );

endmodule

@@ rtl/core/pidc_ctrl.sv @@
module pidc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pidc_pkg::dp_stat_t stat,
  output pidc_pkg::dp_cmd_t  cmd
);
  import pidc_pkg::*;

  state_t  state_r, state_nxt;
  mul_op_t op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_P;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    cmd.op    = op_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd.err   = 1'b1;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        op_nxt    = OP_P;
        state_nxt = ST_MLOAD;
      end
      ST_MLOAD: begin
        cmd.mload = 1'b1;
        state_nxt = ST_MRUN;
      end
      ST_MRUN: begin
        cmd.mstep = 1'b1;
        if (stat.mul_last) state_nxt = ST_MFIN;
      end
      ST_MFIN: begin
        cmd.mfin = 1'b1;
        unique case (op_r)
          OP_P:   begin op_nxt = OP_EDT; state_nxt = ST_MLOAD; end
          OP_EDT: begin op_nxt = OP_INC; state_nxt = ST_MLOAD; end
          OP_INC: begin op_nxt = OP_DM;  state_nxt = ST_MLOAD; end
          OP_DM:  begin op_nxt = OP_P;   state_nxt = ST_INTEG; end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_INTEG: begin
        cmd.integ = 1'b1;
        state_nxt = stat.period_zero ? ST_OUT : ST_DLOAD;
      end
      ST_DLOAD: begin
        cmd.dload = 1'b1;
        state_nxt = ST_DRUN;
      end
      ST_DRUN: begin
        cmd.dstep = 1'b1;
        if (stat.div_last) state_nxt = ST_DFIN;
      end
      ST_DFIN: begin
        cmd.dfin  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.drive = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/core/pidc_dp.sv @@
module pidc_dp #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pidc_pkg::dp_cmd_t                    cmd,
  output pidc_pkg::dp_stat_t                   stat,
  input  logic                                 cfg_we,
  input  logic [pidc_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [DATA_WIDTH-1:0]                cfg_wdata,
  input  logic signed [DATA_WIDTH-1:0]         in_measurement,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [DATA_WIDTH-1:0]         out_drive,
  output logic signed [DATA_WIDTH-1:0]         out_p_term,
  output logic signed [DATA_WIDTH-1:0]         out_i_term,
  output logic signed [DATA_WIDTH-1:0]         out_d_term
);
  import pidc_pkg::*;

  localparam int DW      = DATA_WIDTH;
  localparam int NS      = (DW + DIGIT_W - 1) / DIGIT_W;
  localparam int LO_W    = (NS - 1) * DIGIT_W;
  localparam int PW      = NS * DIGIT_W + DW;
  localparam int TW      = DW + DIGIT_W;
  localparam int FW      = 2 * DW + 1;
  localparam int NW      = DW + FRAC_BITS;
  localparam int MCW     = $clog2(NS + 1);
  localparam int DCW     = $clog2(NW + 1);
  localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [PW-1:0] LO_MASK = (PW'(1) << LO_W) - PW'(1);
  localparam logic [FW-1:0] RND     = (FW'(1) << FRAC_BITS) - FW'(1);
  localparam logic [FW-1:0] LIM_POS = FW'(DMAX);
  localparam logic [FW-1:0] LIM_NEG = FW'(1) << (DW - 1);
  localparam logic [NW-1:0] QLIM_POS = NW'(DMAX);
  localparam logic [NW-1:0] QLIM_NEG = NW'(1) << (DW - 1);

  function automatic logic signed [DW-1:0] sat1(input logic signed [DW:0] x);
    logic signed [DW-1:0] r;
    if (x[DW] != x[DW-1]) r = x[DW] ? DMIN : DMAX;
    else r = x[DW-1:0];
    return r;
  endfunction

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] x);
    logic [DW-1:0] r;
    r = x[DW-1] ? DW'(-x) : DW'(x);
    return r;
  endfunction

  logic signed [DW-1:0] gain_p_r, gain_i_r, gain_d_r, floor_r, ceil_r, target_r;
  logic [DW-2:0]        period_r;

  logic signed [DW-1:0] meas_r, err_r, diff_r, last_err_r, acc_r;
  logic signed [DW-1:0] p_r, edt_r, inc_r, dm_r, d_r;

  logic [DW-1:0]  ma_r;
  logic           mneg_r;
  logic [PW-1:0]  pr_r, pr_nxt;
  logic [MCW-1:0] mcnt_r;
  logic [TW-1:0]  mt;

  logic [DW-1:0]  drem_r, dr2, drem_nxt;
  logic [NW-1:0]  dq_r, dq_nxt;
  logic           dneg_r, dge;
  logic [DCW-1:0] dcnt_r;

  logic signed [DW-1:0] sa, sb, mres, dres, acc_sum, acc_new;
  logic [FW-1:0]        mrnd, msh;
  logic signed [DW+1:0] dsum;
  logic signed [DW-1:0] drive_val;

  logic                 out_valid_r;
  logic signed [DW-1:0] out_drive_r, out_p_r, out_i_r, out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
      floor_r  <= '0;
      ceil_r   <= '0;
      period_r <= '0;
      target_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P:      gain_p_r <= cfg_wdata;
        REG_GAIN_I:      gain_i_r <= cfg_wdata;
        REG_GAIN_D:      gain_d_r <= cfg_wdata;
        REG_INT_FLOOR:   floor_r  <= cfg_wdata;
        REG_INT_CEILING: ceil_r   <= cfg_wdata;
        REG_PERIOD:      period_r <= cfg_wdata[DW-2:0];
        REG_TARGET:      target_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    unique case (cmd.op)
      OP_P:    begin sa = gain_p_r; sb = err_r; end
      OP_EDT:  begin sa = err_r;    sb = $signed({1'b0, period_r}); end
      OP_INC:  begin sa = gain_i_r; sb = edt_r; end
      OP_DM:   begin sa = gain_d_r; sb = diff_r; end
      default: begin sa = '0;       sb = '0; end
    endcase
  end

  // one multiplier digit per cycle, product shifts right
  always_comb begin
    mt     = {{DIGIT_W{1'b0}}, pr_r[PW-1 -: DW]} + TW'(ma_r) * TW'(pr_r[DIGIT_W-1:0]);
    pr_nxt = (PW'(mt) << LO_W) | ((pr_r >> DIGIT_W) & LO_MASK);
  end

  // floor shift and saturate
  always_comb begin
    mrnd = FW'(pr_r[2*DW-1:0]) + (mneg_r ? RND : '0);
    msh  = mrnd >> FRAC_BITS;
    if (msh > (mneg_r ? LIM_NEG : LIM_POS)) mres = mneg_r ? DMIN : DMAX;
    else mres = mneg_r ? -$signed(msh[DW-1:0]) : $signed(msh[DW-1:0]);
  end

  // restoring divide, one quotient bit per cycle
  always_comb begin
    dr2      = {drem_r[DW-2:0], dq_r[NW-1]};
    dge      = dr2 >= {1'b0, period_r};
    drem_nxt = dge ? dr2 - {1'b0, period_r} : dr2;
    dq_nxt   = {dq_r[NW-2:0], dge};
    if (dq_r > (dneg_r ? QLIM_NEG : QLIM_POS)) dres = dneg_r ? DMIN : DMAX;
    else dres = dneg_r ? -$signed(dq_r[DW-1:0]) : $signed(dq_r[DW-1:0]);
  end

  always_comb begin
    acc_sum = sat1({acc_r[DW-1], acc_r} + {inc_r[DW-1], inc_r});
    if (acc_sum < floor_r) acc_new = floor_r;
    else if (acc_sum > ceil_r) acc_new = ceil_r;
    else acc_new = acc_sum;
  end

  always_comb begin
    dsum = {{2{p_r[DW-1]}}, p_r} + {{2{acc_r[DW-1]}}, acc_r} + {{2{d_r[DW-1]}}, d_r};
    if (dsum[DW+1:DW-1] == 3'b000 || dsum[DW+1:DW-1] == 3'b111) drive_val = dsum[DW-1:0];
    else drive_val = dsum[DW+1] ? DMIN : DMAX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r  <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      mcnt_r      <= '0;
      dcnt_r      <= '0;
    end else begin
      if (cmd.load) meas_r <= in_measurement;
      if (cmd.err) err_r <= sat1({target_r[DW-1], target_r} - {meas_r[DW-1], meas_r});
      if (cmd.diff) diff_r <= sat1({err_r[DW-1], err_r} - {last_err_r[DW-1], last_err_r});
      if (cmd.mload) begin
        ma_r   <= mag(sa);
        mneg_r <= sa[DW-1] ^ sb[DW-1];
        pr_r   <= PW'(mag(sb));
        mcnt_r <= '0;
      end else if (cmd.mstep) begin
        pr_r   <= pr_nxt;
        mcnt_r <= mcnt_r + MCW'(1);
      end
      if (cmd.mfin) begin
        unique case (cmd.op)
          OP_P:    p_r   <= mres;
          OP_EDT:  edt_r <= mres;
          OP_INC:  inc_r <= mres;
          OP_DM:   dm_r  <= mres;
          default: ;
        endcase
      end
      if (cmd.integ) begin
        acc_r <= acc_new;
        if (period_r == '0) d_r <= '0;
      end
      if (cmd.dload) begin
        dneg_r <= dm_r[DW-1];
        dq_r   <= {mag(dm_r), {FRAC_BITS{1'b0}}};
        drem_r <= '0;
        dcnt_r <= '0;
      end else if (cmd.dstep) begin
        dq_r   <= dq_nxt;
        drem_r <= drem_nxt;
        dcnt_r <= dcnt_r + DCW'(1);
      end
      if (cmd.dfin) d_r <= dres;
      if (cmd.drive) begin
        out_drive_r <= drive_val;
        out_p_r     <= p_r;
        out_i_r     <= acc_r;
        out_d_r     <= d_r;
        last_err_r  <= err_r;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.mul_last    = mcnt_r == MCW'(NS - 1);
  assign stat.div_last    = dcnt_r == DCW'(NW - 1);
  assign stat.period_zero = period_r == '0;
  assign stat.out_free    = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_drive  = out_drive_r;
  assign out_p_term = out_p_r;
  assign out_i_term = out_i_r;
  assign out_d_term = out_d_r;

endmodule

@@ rtl/core/pidc_chk.sv @@
module pidc_chk #(
  parameter int DATA_WIDTH = 32
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [DATA_WIDTH-1:0] out_drive,
  input logic signed [DATA_WIDTH-1:0] out_p_term,
  input logic signed [DATA_WIDTH-1:0] out_i_term,
  input logic signed [DATA_WIDTH-1:0] out_d_term
);
  localparam int DW = DATA_WIDTH;

  logic signed [DW+1:0] sum;
  logic signed [DW-1:0] drive_exp;

  always_comb begin
    sum = {{2{out_p_term[DW-1]}}, out_p_term} + {{2{out_i_term[DW-1]}}, out_i_term}
        + {{2{out_d_term[DW-1]}}, out_d_term};
    if (sum[DW+1:DW-1] == 3'b000 || sum[DW+1:DW-1] == 3'b111) drive_exp = sum[DW-1:0];
    else drive_exp = sum[DW+1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out valid after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("beat accepted while busy");

  a_drive_is_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive == drive_exp)
    else $error("drive differs from saturated sum of terms");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive) && $stable(out_i_term))
    else $error("stalled out beat changed");

endmodule

bind pid_controller_integral_clamp pidc_chk #(
  .DATA_WIDTH (DATA_WIDTH)
) u_pidc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_drive  (out_ch.drive),
  .out_p_term (out_ch.p_term),
  .out_i_term (out_ch.i_term),
  .out_d_term (out_ch.d_term)
);

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import pidc_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int LATENCY = 4 + 4 * ((DW + 15) / 16 + 2) + (DW + FB + 2);
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_LEN = 600;
  localparam int PRINT_MAX = 40;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS = 170;
  localparam int FULL_RATE_ITEMS = 200;
  localparam logic signed [DW-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [DW-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [DW-1:0] Q_ONE = 32'sh0001_0000;

  typedef struct packed {
    logic signed [DW-1:0] drive;
    logic signed [DW-1:0] p_term;
    logic signed [DW-1:0] i_term;
    logic signed [DW-1:0] d_term;
  } pid_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [DW-1:0]        cfg_wdata;

  pidc_in_if  #(.DATA_WIDTH(DW)) in_bus ();
  pidc_out_if #(.DATA_WIDTH(DW)) out_bus ();

  pid_controller_integral_clamp #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // controller model state
  logic signed [DW-1:0] kp, ki, kd, acc_lo, acc_hi, setpoint;
  logic        [DW-2:0] period;
  logic signed [DW-1:0] integ_acc, prev_err;
  logic signed [DW-1:0] last_drive;

  pid_result_t expected_results[$];

  int n_sent, n_checked, n_writes, n_phases, n_errors, quiet_cycles;
  int hold_requests, hold_seen, hold_left, rx_gap;
  bit tx_idling, rx_idling;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [DW-1:0] clip_q(longint x);
    if (x > longint'(Q_MAX)) return Q_MAX;
    if (x < longint'(Q_MIN)) return Q_MIN;
    return x[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] qmul(longint a, longint b);
    longint prod;
    prod = a * b;
    return clip_q(prod >>> FB);
  endfunction

  function automatic logic signed [DW-1:0] qdiv(longint x, longint p);
    longint num;
    num = x * (longint'(1) << FB);
    return clip_q(num / p);
  endfunction

  function automatic pid_result_t step_controller(logic signed [DW-1:0] meas);
    pid_result_t          r;
    logic signed [DW-1:0] err, edt, diff;
    err = clip_q(longint'(setpoint) - longint'(meas));
    r.p_term = qmul(kp, err);
    edt = qmul(err, longint'(period));
    integ_acc = clip_q(longint'(integ_acc) + longint'(qmul(ki, edt)));
    if (integ_acc < acc_lo) integ_acc = acc_lo;
    else if (integ_acc > acc_hi) integ_acc = acc_hi;
    r.i_term = integ_acc;
    r.d_term = '0;
    if (period != '0) begin
      diff = clip_q(longint'(err) - longint'(prev_err));
      r.d_term = qdiv(qmul(kd, diff), longint'(period));
    end
    r.drive = clip_q(longint'(r.p_term) + longint'(r.i_term) + longint'(r.d_term));
    prev_err = err;
    return r;
  endfunction

  function automatic void store_setting(logic [REG_IDX_W-1:0] idx, logic [DW-1:0] val);
    case (idx)
      REG_GAIN_P:      kp = val;
      REG_GAIN_I:      ki = val;
      REG_GAIN_D:      kd = val;
      REG_INT_FLOOR:   acc_lo = val;
      REG_INT_CEILING: acc_hi = val;
      REG_PERIOD:      period = val[DW-2:0];
      REG_TARGET:      setpoint = val;
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
    if (n_errors < PRINT_MAX)
      $display("%0t: result %0d %s: got %h, expected %h", $time, n_checked, what, got, want);
    n_errors++;
  endtask

  always @(posedge clk) begin
    pid_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat, drive", out_bus.drive, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_bus.drive !== want.drive) report_mismatch("drive", out_bus.drive, want.drive);
        if (out_bus.p_term !== want.p_term) report_mismatch("p_term", out_bus.p_term, want.p_term);
        if (out_bus.i_term !== want.i_term) report_mismatch("i_term", out_bus.i_term, want.i_term);
        if (out_bus.d_term !== want.d_term) report_mismatch("d_term", out_bus.d_term, want.d_term);
      end
      n_checked++;
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results pending", WATCHDOG_LIMIT,
               expected_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    out_bus.ready = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    rx_gap = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        out_bus.ready = 1'b0;
        hold_left--;
      end else if (rx_gap > 0) begin
        out_bus.ready = 1'b0;
        rx_gap--;
      end else begin
        out_bus.ready = 1'b1;
        if (rx_idling && $urandom_range(0, 7) == 0) rx_gap = $urandom_range(1, 10);
      end
    end
  end

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DW-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    store_setting(idx, val);
    n_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_sample(logic signed [DW-1:0] meas);
    pid_result_t r;
    in_bus.valid = 1'b1;
    in_bus.measurement = meas;
    do @(posedge clk); while (!in_bus.ready);
    r = step_controller(meas);
    last_drive = r.drive;
    expected_results.push_back(r);
    n_sent++;
    @(negedge clk);
    if (tx_idling && $urandom_range(0, 5) == 0) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  task automatic settle();
    in_bus.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [DW-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      default: return $urandom_range(0, 262144) - 131072;
    endcase
  endfunction

  function automatic logic [DW-1:0] pick_period();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return $urandom_range(1, 131072);
      2:       return $urandom;
      3:       return $urandom_range(1, 64);
      default: return $urandom_range(256, 65536);
    endcase
  endfunction

  function automatic logic signed [DW-1:0] pick_measurement(logic signed [DW-1:0] plant);
    int unsigned sel;
    int          off;
    sel = $urandom_range(0, 15);
    if (sel == 0) return $urandom;
    if (sel == 1) return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
    if (sel < 8) begin
      off = int'($urandom_range(0, 262144)) - 131072;
      return clip_q(longint'(setpoint) + longint'(off));
    end
    off = int'($urandom_range(0, 8192)) - 4096;
    return clip_q(longint'(plant) + (longint'(last_drive) >>> 3) + longint'(off));
  endfunction

  task automatic pick_limits();
    logic [DW-1:0] span;
    case ($urandom_range(0, 3))
      0: begin
        span = $urandom_range(0, 2097152);
        write_reg(REG_INT_FLOOR, -span);
        write_reg(REG_INT_CEILING, span);
      end
      1: begin
        write_reg(REG_INT_FLOOR, $urandom);
        write_reg(REG_INT_CEILING, $urandom);
      end
      2: begin
        write_reg(REG_INT_FLOOR, Q_MIN);
        write_reg(REG_INT_CEILING, Q_MAX);
      end
      default: begin
        span = $urandom_range(1, 524288);
        write_reg(REG_INT_FLOOR, span);
        write_reg(REG_INT_CEILING, -span);
      end
    endcase
  endtask

  task automatic apply_random_settings();
    write_reg(REG_GAIN_P, pick_gain());
    write_reg(REG_GAIN_I, pick_gain());
    write_reg(REG_GAIN_D, pick_gain());
    pick_limits();
    write_reg(REG_PERIOD, pick_period());
    if ($urandom_range(0, 3) == 0) write_reg(REG_TARGET, $urandom);
    else write_reg(REG_TARGET, $urandom_range(0, 2097152) - 1048576);
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom);
    n_phases++;
  endtask

  task automatic run_random_samples(int count);
    logic signed [DW-1:0] plant;
    plant = setpoint;
    repeat (count) begin
      plant = pick_measurement(plant);
      send_sample(plant);
    end
  endtask

  task automatic test_reset_state();
    settle();
    send_sample('0);
    send_sample(Q_MAX);
    send_sample(Q_MIN);
    send_sample(-32'sd1);
  endtask

  task automatic test_nominal_loop();
    settle();
    write_reg(REG_GAIN_P, Q_ONE);
    write_reg(REG_GAIN_I, Q_ONE);
    write_reg(REG_GAIN_D, Q_ONE);
    write_reg(REG_INT_FLOOR, -32'sh0010_0000);
    write_reg(REG_INT_CEILING, 32'sh0010_0000);
    write_reg(REG_PERIOD, Q_ONE);
    write_reg(REG_TARGET, 32'sh0005_0000);
    n_phases++;
    send_sample(32'sh0002_0000);
    send_sample(32'sh0005_0000);
    send_sample(Q_MIN);
    send_sample(Q_MAX);
    send_sample(32'sh0004_8000);
  endtask

  task automatic test_extreme_gains();
    settle();
    write_reg(REG_GAIN_P, Q_MAX);
    write_reg(REG_GAIN_I, Q_MIN);
    write_reg(REG_GAIN_D, Q_MIN);
    write_reg(REG_INT_FLOOR, Q_MIN);
    write_reg(REG_INT_CEILING, Q_MAX);
    write_reg(REG_PERIOD, 32'hffff_ffff);
    write_reg(REG_TARGET, Q_MIN);
    n_phases++;
    send_sample(Q_MAX);
    send_sample(Q_MIN);
    send_sample('0);
    send_sample(-32'sd1);
  endtask

  task automatic test_zero_period();
    settle();
    write_reg(REG_GAIN_P, Q_ONE);
    write_reg(REG_GAIN_I, Q_ONE);
    write_reg(REG_GAIN_D, Q_ONE);
    write_reg(REG_PERIOD, '0);
    write_reg(REG_TARGET, '0);
    n_phases++;
    send_sample(32'sh0001_0000);
    send_sample(-32'sh0003_0000);
    send_sample(32'sh0000_7000);
  endtask

  task automatic test_floor_above_ceiling();
    settle();
    write_reg(REG_PERIOD, Q_ONE);
    write_reg(REG_INT_FLOOR, 32'sh0004_0000);
    write_reg(REG_INT_CEILING, -32'sh0004_0000);
    n_phases++;
    send_sample(-32'sh0010_0000);
    send_sample('0);
    send_sample(32'sh0010_0000);
    send_sample(32'sh0010_0000);
  endtask

  task automatic test_tiny_period();
    settle();
    write_reg(REG_PERIOD, 32'h8000_0001);
    n_phases++;
    send_sample(32'sh0001_0000);
    send_sample(-32'sh0001_0000);
  endtask

  task automatic test_unused_index();
    settle();
    write_reg(REG_UNUSED, 32'hffff_ffff);
    send_sample(32'sh0000_4000);
    send_sample(-32'sh0000_4000);
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      apply_random_settings();
      run_random_samples(PHASE_ITEMS);
    end
  endtask

  task automatic test_output_stall();
    settle();
    apply_random_settings();
    hold_requests++;
    run_random_samples(12);
  endtask

  task automatic test_full_rate();
    settle();
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    apply_random_settings();
    run_random_samples(FULL_RATE_ITEMS);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_GAIN_P;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.measurement = '0;
    tx_idling = 1'b1;
    rx_idling = 1'b1;
    hold_requests = 0;
    kp = '0;
    ki = '0;
    kd = '0;
    acc_lo = '0;
    acc_hi = '0;
    setpoint = '0;
    period = '0;
    integ_acc = '0;
    prev_err = '0;
    last_drive = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_nominal_loop();
    test_extreme_gains();
    test_zero_period();
    test_floor_above_ceiling();
    test_tiny_period();
    test_unused_index();
    test_random_settings();
    test_output_stall();
    test_full_rate();

    settle();
    repeat (LATENCY + 30) @(negedge clk);
    $display("Covered %0d samples, %0d results checked, across %0d controller settings",
             n_sent, n_checked, n_phases);
    $display("%0d register writes incl. unused index; long output stall; full-rate tail",
             n_writes);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
